// ----- rtl/bscs_pkg.sv -----
package bscs_pkg;

   localparam int MaxNodesDefault = 16;
   localparam int CoordW = 16;
   localparam int RadiusW = 17;
   localparam int DistW = 18;
   localparam int BoundW = 19;
   localparam int SqW = 36;
   localparam int RootSteps = 18;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_QUERY = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_CLOSEST = 2'd0,
      KIND_CANDIDATE = 2'd1,
      KIND_EMPTY = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIST,
      ST_ROOT,
      ST_REPORT,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic [0:0] opcode;
      logic [3:0] entry_index;
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
      logic signed [CoordW-1:0] pos_z;
      logic [RadiusW-1:0] sphere_radius;
   } req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [3:0] node_index;
      logic [BoundW-1:0] bound_distance;
      logic last;
   } rsp_type;

endpackage

// ----- rtl/bscs_req_if.sv -----
interface bscs_req_if
   import bscs_pkg::*;
   ();
   logic valid;
   logic ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/bscs_rsp_if.sv -----
interface bscs_rsp_if
   import bscs_pkg::*;
   ();
   logic valid;
   logic ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/bscs_sqrt.sv -----
// Bit-serial floor square root, one step per cycle.
module bscs_sqrt
   import bscs_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic [SqW-1:0] radicand,
   output logic done,
   output logic [DistW-1:0] root
);
   logic [SqW-1:0] rem_ff, rem_in;
   logic [SqW-1:0] res_ff, res_in;
   logic [SqW-1:0] bit_ff, bit_in;
   logic [4:0] step_ff, step_in;
   logic busy_ff, busy_in;
   logic [SqW-1:0] trial;

   assign trial = res_ff + bit_ff;

   // One root step per cycle while busy.
   always_comb begin
      rem_in = rem_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in = radicand;
         res_in = '0;
         bit_in = SqW'(1) << (SqW - 2);
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         step_in = step_ff + 5'd1;
         if (step_ff == 5'(RootSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign done = busy_ff && (step_ff == 5'(RootSteps - 1));
   assign root = DistW'(res_in);
endmodule

// ----- rtl/bounding_sphere_cull_search.sv -----
// Channel | Dir | Handshake      | Payload
// req     | in  | valid / ready  | opcode, entry_index, pos_x/y/z, sphere_radius
// rsp     | out | valid / ready  | result_kind, node_index, bound_distance, last
// csr     | in  | we             | node_count (5 bits)
//
// A load is taken in idle and gives no result. A query over N entries in use runs a
// distance pass per entry (the squared distance, then a start and run of the
// 18-step square root unit), a setup step for the scan, a candidate scan over each
// entry through the registered-read memories, and a step to flag the final result.
// A query on an empty table gives one empty result straight from idle. Reset is
// synchronous and clears control state only. Each cycle a result waits on rsp ready
// holds the scan, the final result, or the idle state, where it stands.
module bounding_sphere_cull_search
   import bscs_pkg::*;
#(
   parameter int MAX_NODES = MaxNodesDefault
) (
   input logic clock,
   input logic reset,
   bscs_req_if.sink req,
   bscs_rsp_if.source rsp,
   input logic csr_we,
   input logic [4:0] csr_wdata
);
   localparam int IdxW = $clog2(MAX_NODES);
   localparam int CntW = $clog2(MAX_NODES + 1);

   typedef struct packed {
      logic [CoordW-1:0] cx;
      logic [CoordW-1:0] cy;
      logic [CoordW-1:0] cz;
      logic [RadiusW-1:0] rad;
   } entry_type;

   // Sphere table and distance store.
   entry_type tbl_mem [MAX_NODES];
   logic [DistW-1:0] dist_mem [MAX_NODES];
   entry_type tbl_rd_ff;
   logic [DistW-1:0] dist_rd_ff;

   state_type state_ff, state_in;
   logic [4:0] count_ff;
   logic [CntW-1:0] used;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic [IdxW-1:0] best_ff, best_in;
   logic [DistW:0] bound_ff, bound_in;
   logic have_ff, have_in;
   logic signed [CoordW-1:0] px_ff, py_ff, pz_ff;
   logic [SqW-1:0] sq_ff;
   logic sq_start_ff;
   logic out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   rsp_type hold_ff, hold_in;
   logic last_idx;
   logic req_take;

   logic root_done;
   logic [DistW-1:0] root;

   logic signed [CoordW:0] dx, dy, dz;
   logic signed [2*CoordW+1:0] sqx, sqy, sqz;
   logic [DistW:0] t_sum;
   logic qualifies;
   logic out_free;

   assign used = (int'(count_ff) > MAX_NODES) ? CntW'(MAX_NODES) : CntW'(count_ff);
   assign last_idx = (CntW'(idx_ff) == used - CntW'(1));
   assign req_take = req.valid && req.ready;

   bscs_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start_ff), .radicand(sq_ff),
      .done(root_done), .root(root)
   );

   // Table writes and registered reads.
   always_ff @(posedge clock) begin
      if (req_take && req.payload.opcode == OP_LOAD
          && 32'(req.payload.entry_index) < MAX_NODES) begin
         tbl_mem[IdxW'(req.payload.entry_index)] <= '{req.payload.pos_x,
            req.payload.pos_y, req.payload.pos_z, req.payload.sphere_radius};
      end
      if (state_ff == ST_ROOT && root_done) begin
         dist_mem[idx_ff] <= root;
      end
      tbl_rd_ff <= tbl_mem[idx_in];
      dist_rd_ff <= dist_mem[idx_in];
   end

   // Squared distance of the current entry, registered before the root.
   assign dx = (CoordW+1)'(px_ff) - (CoordW+1)'($signed(tbl_rd_ff.cx));
   assign dy = (CoordW+1)'(py_ff) - (CoordW+1)'($signed(tbl_rd_ff.cy));
   assign dz = (CoordW+1)'(pz_ff) - (CoordW+1)'($signed(tbl_rd_ff.cz));
   assign sqx = dx * dx;
   assign sqy = dy * dy;
   assign sqz = dz * dz;

   assign t_sum = (DistW+1)'(root) + (DistW+1)'(tbl_rd_ff.rad);
   assign qualifies = (idx_ff != best_ff) &&
      ((DistW+1)'(dist_rd_ff) <= bound_ff + (DistW+1)'(tbl_rd_ff.rad));

   assign out_free = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_IDLE) && out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && req.payload.opcode == OP_QUERY && used != '0) begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: state_in = ST_ROOT;
         ST_ROOT: begin
            if (root_done) begin
               state_in = last_idx ? ST_REPORT : ST_DIST;
            end
         end
         ST_REPORT: state_in = ST_SCAN;
         ST_SCAN: begin
            if ((!qualifies || out_free) && last_idx) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs. Each result is held until the next one is found, so the
   // final one can carry the last flag.
   always_comb begin
      idx_in = idx_ff;
      best_in = best_ff;
      bound_in = bound_ff;
      have_in = have_ff;
      hold_in = hold_ff;
      out_in = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            have_in = 1'b0;
            if (req_take && req.payload.opcode == OP_QUERY && used == '0) begin
               out_valid_in = 1'b1;
               out_in = '{KIND_EMPTY, 4'd0, BoundW'(0), 1'b1};
            end
         end
         ST_ROOT: begin
            if (root_done) begin
               if (!have_ff || t_sum < bound_ff) begin
                  have_in = 1'b1;
                  bound_in = t_sum;
                  best_in = idx_ff;
               end
               if (!last_idx) idx_in = idx_ff + IdxW'(1);
            end
         end
         ST_REPORT: begin
            hold_in = '{KIND_CLOSEST, 4'(best_ff), BoundW'(bound_ff), 1'b0};
            idx_in = '0;
         end
         ST_SCAN: begin
            if (qualifies && out_free) begin
               out_valid_in = 1'b1;
               out_in = hold_ff;
               hold_in = '{KIND_CANDIDATE, 4'(idx_ff), BoundW'(bound_ff), 1'b0};
            end
            if ((!qualifies || out_free) && !last_idx) idx_in = idx_ff + IdxW'(1);
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_in = hold_ff;
               out_in.last = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      best_ff <= best_in;
      bound_ff <= bound_in;
      have_ff <= have_in;
      hold_ff <= hold_in;
      if (req_take) begin
         px_ff <= req.payload.pos_x;
         py_ff <= req.payload.pos_y;
         pz_ff <= req.payload.pos_z;
      end
      sq_ff <= SqW'(sqx) + SqW'(sqy) + SqW'(sqz);
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         out_valid_ff <= 1'b0;
         sq_start_ff <= 1'b0;
         out_ff <= '0;
      end else begin
         state_ff <= state_in;
         sq_start_ff <= (state_ff == ST_DIST);
         if (csr_we) count_ff <= csr_wdata;
         out_valid_ff <= out_valid_in;
         out_ff <= out_in;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule

// ----- tb/bounding_sphere_cull_search_tb.sv -----
`timescale 1ns / 100ps

module bounding_sphere_cull_search_tb;
   import bscs_pkg::*;

   localparam int TableDepth = 16;
   localparam int StallLimit = 6000;
   localparam int SettleCycles = 60;

   // Prediction of the sphere table and of every query's expected reports.
   class cull_scoreboard;
      logic signed [CoordW-1:0] cx[TableDepth];
      logic signed [CoordW-1:0] cy[TableDepth];
      logic signed [CoordW-1:0] cz[TableDepth];
      logic [RadiusW-1:0] rad[TableDepth];
      logic [4:0] count;
      rsp_type expected_reports[$];
      int errors;

      function new();
         count = 0;
         errors = 0;
      endfunction

      // Floor square root in 18 bit-serial steps.
      function automatic logic [DistW-1:0] floor_root(logic [63:0] v);
         logic [63:0] rem;
         logic [63:0] res;
         logic [63:0] bit_w;
         rem = v;
         res = 0;
         bit_w = 64'd1 << 34;
         for (int k = 0; k < RootSteps; k++) begin
            if (rem >= res + bit_w) begin
               rem = rem - (res + bit_w);
               res = (res >> 1) + bit_w;
            end else begin
               res = res >> 1;
            end
            bit_w = bit_w >> 2;
         end
         return res[DistW-1:0];
      endfunction

      // Note one accepted request: a load updates the table, a query yields reports.
      function void note_request(req_type r);
         int used;
         int best;
         longint dx, dy, dz;
         logic [63:0] sq;
         logic [DistW-1:0] root_dist[TableDepth];
         logic [BoundW-1:0] bound;
         logic [BoundW-1:0] total;
         rsp_type e;
         if (opcode_type'(r.opcode) == OP_LOAD) begin
            cx[r.entry_index] = r.pos_x;
            cy[r.entry_index] = r.pos_y;
            cz[r.entry_index] = r.pos_z;
            rad[r.entry_index] = r.sphere_radius;
            return;
         end
         used = (count > TableDepth) ? TableDepth : count;
         if (used == 0) begin
            e.result_kind = KIND_EMPTY;
            e.node_index = 4'd0;
            e.bound_distance = '0;
            e.last = 1'b1;
            expected_reports.push_back(e);
            return;
         end
         best = 0;
         bound = 0;
         for (int i = 0; i < used; i++) begin
            dx = longint'(r.pos_x) - longint'(cx[i]);
            dy = longint'(r.pos_y) - longint'(cy[i]);
            dz = longint'(r.pos_z) - longint'(cz[i]);
            sq = dx * dx + dy * dy + dz * dz;
            root_dist[i] = floor_root(sq);
            total = BoundW'(root_dist[i]) + BoundW'(rad[i]);
            if (i == 0 || total < bound) begin
               bound = total;
               best = i;
            end
         end
         e.result_kind = KIND_CLOSEST;
         e.node_index = 4'(best);
         e.bound_distance = bound;
         e.last = 1'b0;
         expected_reports.push_back(e);
         // An entry qualifies when distance minus radius is within the bound.
         for (int i = 0; i < used; i++) begin
            if (i != best && 20'(root_dist[i]) <= 20'(bound) + 20'(rad[i])) begin
               e.result_kind = KIND_CANDIDATE;
               e.node_index = 4'(i);
               expected_reports.push_back(e);
            end
         end
         expected_reports[$].last = 1'b1;
      endfunction

      // Compare one accepted report with the oldest expectation.
      function void check_report(rsp_type a);
         rsp_type e;
         if (expected_reports.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected report: kind %0d index %0d bound %0d last %0d",
                        a.result_kind, a.node_index, a.bound_distance, a.last);
            return;
         end
         e = expected_reports.pop_front();
         if (a.result_kind !== e.result_kind || a.node_index !== e.node_index ||
             a.bound_distance !== e.bound_distance || a.last !== e.last) begin
            errors++;
            if (errors <= 10)
               $display({"mismatch: expected kind %0d index %0d bound %0d last %0d, ",
                         "got kind %0d index %0d bound %0d last %0d"},
                        e.result_kind, e.node_index, e.bound_distance, e.last,
                        a.result_kind, a.node_index, a.bound_distance, a.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_we;
   logic [4:0] csr_wdata;
   logic calm;
   int idle_cycles;
   cull_scoreboard sb;

   bscs_req_if req ();
   bscs_rsp_if rsp ();

   bounding_sphere_cull_search dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Monitor both channels at the rising edge and keep the stall watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if (req.valid && req.ready)
            sb.note_request(req.payload);
         if (rsp.valid && rsp.ready)
            sb.check_report(rsp.payload);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Result ready toggles in random bursts until the calm part of the run.
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (calm) begin
            rsp.ready <= 1'b1;
            @(negedge clock);
         end else begin
            rsp.ready <= $urandom_range(0, 1);
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // Present one request and hold it until its transfer; returns at a falling edge.
   task automatic send_request(req_type r);
      if (!calm && $urandom_range(0, 2) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic send_load(int idx, int x, int y, int z, int r);
      req_type q;
      q.opcode = OP_LOAD;
      q.entry_index = 4'(idx);
      q.pos_x = 16'(x);
      q.pos_y = 16'(y);
      q.pos_z = 16'(z);
      q.sphere_radius = 17'(r);
      send_request(q);
   endtask

   task automatic send_query(int x, int y, int z);
      req_type q;
      q.opcode = OP_QUERY;
      q.entry_index = 4'($urandom);
      q.pos_x = 16'(x);
      q.pos_y = 16'(y);
      q.pos_z = 16'(z);
      q.sphere_radius = 17'($urandom);
      send_request(q);
   endtask

   // Let every expected report arrive, then give the block time to settle.
   task automatic drain();
      req.valid <= 1'b0;
      while (sb.expected_reports.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      @(negedge clock);
   endtask

   // The count register is only written while the block is idle.
   task automatic write_count(int v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= 5'(v);
      sb.count = 5'(v);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic int rand_coord();
      case ($urandom_range(0, 5))
         0: return -32768;
         1: return 32767;
         2: return $urandom_range(0, 255) - 128;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   function automatic int rand_radius();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return 131071;
         2: return $urandom_range(0, 4095);
         default: return $urandom_range(0, 131071);
      endcase
   endfunction

   // Random traffic: mostly queries, some near a loaded center, some loads.
   task automatic random_phase(int items);
      int k;
      for (int n = 0; n < items; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            send_load($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord(),
                      rand_radius());
         end else if ($urandom_range(0, 1) == 0) begin
            k = $urandom_range(0, 15);
            send_query(sb.cx[k] + $urandom_range(0, 2047) - 1024,
                       sb.cy[k] + $urandom_range(0, 2047) - 1024,
                       sb.cz[k] + $urandom_range(0, 2047) - 1024);
         end else begin
            send_query(rand_coord(), rand_coord(), rand_coord());
         end
      end
   endtask

   initial begin
      int counts[8] = '{16, 1, 31, 2, 17, 5, 16, 0};
      sb = new();
      calm = 1'b0;
      idle_cycles = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.payload = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty table, extreme entries, a tie, then extreme queries.
      send_query(0, 0, 0);
      send_load(0, -32768, -32768, -32768, 0);
      send_load(1, 32767, 32767, 32767, 131071);
      send_load(2, 0, 0, 0, 256);
      send_load(3, 1000, -2000, 3000, 500);
      send_load(4, 1000, -2000, 3000, 500);
      for (int i = 5; i < TableDepth; i++)
         send_load(i, rand_coord(), rand_coord(), rand_coord(), rand_radius());
      write_count(16);
      send_query(-32768, -32768, -32768);
      send_query(32767, 32767, 32767);
      send_query(0, 0, 0);
      send_query(1000, -2000, 3000);
      send_query(-32768, 32767, 0);
      write_count(1);
      send_query(32767, -32768, 100);
      write_count(31);
      send_query(5, -5, 5);

      // Random phases over several counts; from the last one on, without idling.
      for (int p = 0; p < 8; p++) begin
         write_count(p == 7 ? $urandom_range(0, 31) : counts[p]);
         if (p == 7)
            calm = 1'b1;
         random_phase(p == 0 ? 0 : 20);
         if (p == 0)
            send_query(0, 0, 0);
      end
      write_count(counts[0]);
      random_phase(20);

      drain();
      if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
